/* hdl/vcsm_pkg.sv */
// Shared types and constants for the sign-magnitude varint codec.
`default_nettype none

package vcsm_pkg;

  localparam int unsigned GROUP_BITS = 7;
  localparam logic [6:0] GROUP_MASK = 7'h7f;
  localparam logic [7:0] MORE_BIT = 8'h80;
  localparam int unsigned MORE_POS = 7;
  localparam logic [6:0] OFFSET_LIMIT = 7'd64;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic [1:0] FMT_U32 = 2'd0;
  localparam logic [1:0] FMT_U64 = 2'd1;
  localparam logic [1:0] FMT_S32 = 2'd2;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  typedef struct packed {
    logic enc_load;
    logic enc_emit;
    logic dec_step;
  } vcsm_cmd_t;

  typedef struct packed {
    logic out_free;
    logic enc_last;
  } vcsm_status_t;

endpackage

`default_nettype wire

/* hdl/vcsm_if.sv */
// Request and result channel interfaces of the varint codec.
`default_nettype none

interface vcsm_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [1:0]  format;
  logic [63:0] value;
  logic [7:0]  byte_in;

  modport source (output valid, operation, format, value, byte_in, input ready);
  modport sink (input valid, operation, format, value, byte_in, output ready);
endinterface

interface vcsm_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  byte_out;
  logic        byte_last;
  logic [63:0] value_out;

  modport source (output valid, kind, byte_out, byte_last, value_out, input ready);
  modport sink (input valid, kind, byte_out, byte_last, value_out, output ready);
endinterface

`default_nettype wire

/* hdl/vcsm_ctrl.sv */
// Controller FSM of the varint codec: accepts requests and paces encode bytes.
`default_nettype none

module vcsm_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_op_i,
  input  wire vcsm_pkg::vcsm_status_t status_i,
  output logic                       in_ready_o,
  output vcsm_pkg::vcsm_cmd_t        cmd_o
);
  import vcsm_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ENC  = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_ready_o = (state_q == ST_IDLE) && status_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.enc_load = accept && (in_op_i == OP_ENCODE);
    cmd_o.dec_step = accept && (in_op_i == OP_DECODE);
    cmd_o.enc_emit = (state_q == ST_ENC) && status_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.enc_load) state_d = ST_ENC;
      end
      ST_ENC: begin
        if (cmd_o.enc_emit && status_i.enc_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/vcsm_dp.sv */
// Datapath of the varint codec: encode shifter, decode accumulator, result register.
`default_nettype none

module vcsm_dp #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire vcsm_pkg::vcsm_cmd_t   cmd_i,
  output vcsm_pkg::vcsm_status_t     status_o,
  input  wire logic [1:0]            format_i,
  input  wire logic [63:0]           value_i,
  input  wire logic [7:0]            byte_in_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       kind_o,
  output logic [7:0]                 byte_out_o,
  output logic                       byte_last_o,
  output logic [63:0]                value_out_o
);
  import vcsm_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH;

  logic [VW-1:0]   sh_q, sh_d;
  logic [VW-1:0]   rest;
  logic            more;
  logic [VW-1:0]   wire_val;
  logic [31:0]     enc_x, enc_mag;

  logic [VW-1:0]   acc_q, acc_d, acc_new;
  logic [6:0]      off_q, off_d;
  logic [VW+6:0]   grp_ext;
  logic            term;
  logic [31:0]     dec_u;
  logic [63:0]     dec_mag, dec_val;

  logic            out_valid_q;
  logic            out_load;
  logic            kind_q, kind_d;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d;
  logic [63:0]     val_q, val_d;

  // encode side
  assign enc_x   = value_i[31:0];
  assign enc_mag = enc_x[31] ? (32'd0 - enc_x) : enc_x;

  always_comb begin
    case (format_i)
      FMT_U32: wire_val = VW'(enc_x);
      FMT_S32: wire_val = VW'({enc_mag[30:0], enc_x[31]});
      default: wire_val = value_i[VW-1:0];
    endcase
  end

  assign rest = sh_q >> GROUP_BITS;
  assign more = |rest;

  always_comb begin
    sh_d = sh_q;
    if (cmd_i.enc_load)      sh_d = wire_val;
    else if (cmd_i.enc_emit) sh_d = rest;
  end

  // decode side
  assign term    = ~byte_in_i[MORE_POS];
  assign grp_ext = (VW + 7)'(byte_in_i[6:0] & GROUP_MASK) << off_q[5:0];
  assign acc_new = (off_q < OFFSET_LIMIT) ? (acc_q | grp_ext[VW-1:0]) : acc_q;
  assign dec_u   = acc_new[31:0];
  assign dec_mag = {33'd0, dec_u[31:1]};

  always_comb begin
    case (format_i)
      FMT_U32: dec_val = {32'd0, dec_u};
      FMT_S32: dec_val = dec_u[0] ? (64'd0 - dec_mag) : dec_mag;
      default: dec_val = 64'(acc_new);
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    off_d = off_q;
    if (cmd_i.dec_step) begin
      if (term) begin
        acc_d = '0;
        off_d = '0;
      end else begin
        acc_d = acc_new;
        if (off_q < OFFSET_LIMIT) off_d = off_q + 7'(GROUP_BITS);
      end
    end
  end

  // result register
  assign out_load = cmd_i.enc_emit || (cmd_i.dec_step && term);

  always_comb begin
    kind_d = kind_q;
    byte_d = byte_q;
    last_d = last_q;
    val_d  = val_q;
    if (cmd_i.enc_emit) begin
      kind_d = KIND_BYTE;
      byte_d = {more, sh_q[6:0]};
      last_d = ~more;
      val_d  = '0;
    end else if (cmd_i.dec_step && term) begin
      kind_d = KIND_VALUE;
      byte_d = '0;
      last_d = 1'b0;
      val_d  = dec_val;
    end
  end

  assign status_o.out_free = ~out_valid_q || out_ready_i;
  assign status_o.enc_last = ~more;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      off_q       <= '0;
    end else begin
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      acc_q <= acc_d;
      off_q <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    kind_q <= kind_d;
    byte_q <= byte_d;
    last_q <= last_d;
    val_q  <= val_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign byte_out_o  = byte_q;
  assign byte_last_o = last_q;
  assign value_out_o = val_q;

endmodule

`default_nettype wire

/* hdl/varint_codec_sign_magnitude_unit.sv */
// Varint codec top level: 7-bit groups, sign-magnitude signed format.
//
// Usage: requests enter on in_i (valid/ready). operation selects encode of
// value or decode of byte_in; format selects unsigned 32-bit, unsigned wide
// (VALUE_WIDTH bits) or signed 32-bit sign-magnitude. Results leave on out_o.
// An encode request produces 1 to ceil(VALUE_WIDTH/7) byte results, the last
// one flagged by byte_last. A decode request produces one value result when
// its byte has bit 7 clear, and none otherwise.
// Timing: a decode result is registered and appears in the cycle after the
// request is accepted; the first encode byte passes the shift register, then
// the result register. An encode request holds the block until its last
// byte, one byte per cycle while out_o does not stall; a decode request
// leaves it free. The single result register sets the pace.
// Reset clears the decode accumulator, the bit offset and the result valid.
// When the receiver stalls, the result register holds and no further bytes
// or requests are taken until it drains.
`default_nettype none

module varint_codec_sign_magnitude_unit #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vcsm_in_if.sink    in_i,
  vcsm_out_if.source out_o
);
  import vcsm_pkg::*;

  vcsm_cmd_t    cmd;
  vcsm_status_t status;
  logic         in_ready;

  vcsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  vcsm_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .format_i    (in_i.format),
    .value_i     (in_i.value),
    .byte_in_i   (in_i.byte_in),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .kind_o      (out_o.kind),
    .byte_out_o  (out_o.byte_out),
    .byte_last_o (out_o.byte_last),
    .value_out_o (out_o.value_out)
  );

  assign in_i.ready = in_ready;

`ifndef SYNTHESIS
  a_no_req_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.enc_emit |-> !in_ready)
    else $error("request taken while encode bytes pending");

  a_last_matches_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == KIND_BYTE) |->
      (out_o.byte_last == !out_o.byte_out[MORE_POS]) && (out_o.value_out == 64'd0))
    else $error("encoded byte flags inconsistent");

  a_value_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == KIND_VALUE) |->
      (out_o.byte_out == 8'd0) && !out_o.byte_last)
    else $error("decoded value result carries byte fields");
`endif

endmodule

`default_nettype wire
